FILE: rtl/core/shdd_pkg.sv
`timescale 1ns / 1ps
// shared constants, register codes and fixed-point helpers for the hill derivative block
package shdd_pkg;

    localparam int TRIG_FRAC  = 30;
    localparam int MID_WIDTH  = 40;
    localparam int COEF_WIDTH = 32;
    localparam int TRIG_WIDTH = 33;
    localparam int ZW         = 33;
    localparam int MAX_STAGES = 32;

    localparam logic signed [TRIG_WIDTH-1:0] CORDIC_GAIN = 33'sd652032874;

    localparam logic [1:0] REG_COEF_QUAD  = 2'd0;
    localparam logic [1:0] REG_COEF_LIN   = 2'd1;
    localparam logic [1:0] REG_COEF_CONST = 2'd2;
    localparam logic [1:0] REG_SRP_SCALE  = 2'd3;

    // arctangent of 2^-i in 32-bit turns
    function automatic logic [31:0] atan_turn(input int i);
        logic [31:0] v;
        case (i)
            0:       v = 32'h20000000;
            1:       v = 32'h12E4051E;
            2:       v = 32'h09FB385B;
            3:       v = 32'h051111D4;
            4:       v = 32'h028B0D43;
            5:       v = 32'h0145D7E1;
            6:       v = 32'h00A2F61E;
            7:       v = 32'h00517C55;
            8:       v = 32'h0028BE53;
            9:       v = 32'h00145F2F;
            10:      v = 32'h000A2F98;
            11:      v = 32'h000517CC;
            12:      v = 32'h00028BE6;
            13:      v = 32'h000145F3;
            14:      v = 32'h0000A2FA;
            15:      v = 32'h0000517D;
            16:      v = 32'h000028BE;
            17:      v = 32'h0000145F;
            18:      v = 32'h00000A30;
            19:      v = 32'h00000518;
            20:      v = 32'h0000028C;
            21:      v = 32'h00000146;
            22:      v = 32'h000000A3;
            23:      v = 32'h00000051;
            24:      v = 32'h00000029;
            25:      v = 32'h00000014;
            26:      v = 32'h0000000A;
            27:      v = 32'h00000005;
            28:      v = 32'h00000003;
            29:      v = 32'h00000001;
            30:      v = 32'h00000001;
            default: v = 32'h00000000;
        endcase
        return v;
    endfunction

    // signed product, rounded half away from zero, saturated to w bits
    function automatic logic signed [63:0] mul_rnd(
        input logic signed [63:0] a,
        input logic signed [63:0] b,
        input int                 sh,
        input int                 w
    );
        logic         neg;
        logic [63:0]  ma;
        logic [63:0]  mb;
        logic [127:0] p;
        logic [127:0] lim;
        neg = a[63] ^ b[63];
        ma  = a[63] ? 64'(-a) : 64'(a);
        mb  = b[63] ? 64'(-b) : 64'(b);
        p   = 128'(ma) * 128'(mb);
        if (sh > 0)
        begin
            p = (p + (128'(1) << (sh - 1))) >> sh;
        end
        lim = (128'(1) << (w - 1)) - (neg ? 128'(0) : 128'(1));
        if (p > lim)
        begin
            p = lim;
        end
        return neg ? -$signed(p[63:0]) : $signed(p[63:0]);
    endfunction

endpackage

FILE: rtl/core/shdd_cordic.sv
`timescale 1ns / 1ps
// pipelined cordic giving cosine and sine of a binary angle in q2.30
module shdd_cordic
    import shdd_pkg::*;
#(
    parameter int ANGLE_WIDTH = 16,
    parameter int STAGES      = 16
)
(
    input  logic                         clk,
    input  logic                         en,
    input  logic [ANGLE_WIDTH-1:0]       angle,
    output logic signed [TRIG_WIDTH-1:0] cos_out,
    output logic signed [TRIG_WIDTH-1:0] sin_out
);

    localparam int NS = (STAGES > MAX_STAGES) ? MAX_STAGES : STAGES;

    logic signed [TRIG_WIDTH-1:0] x_reg [0:NS];
    logic signed [TRIG_WIDTH-1:0] y_reg [0:NS];
    logic signed [ZW-1:0]         z_reg [0:NS];
    logic [1:0]                   q_reg [0:NS];

    logic [31:0]          a_turn;
    logic [31:0]          a_sum;
    logic [31:0]          a_res;
    logic [1:0]           quad;
    logic signed [ZW-1:0] z_init;

    // quadrant split, residual in [-45, 45) degrees
    always_comb
    begin
        a_turn = {angle, {(32 - ANGLE_WIDTH){1'b0}}};
        a_sum  = a_turn + 32'h2000_0000;
        quad   = a_sum[31:30];
        a_res  = a_turn - {quad, 30'd0};
        z_init = ZW'($signed(a_res));
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_reg[0] <= CORDIC_GAIN;
            y_reg[0] <= '0;
            z_reg[0] <= z_init;
            q_reg[0] <= quad;
        end
    end

    for (genvar i = 0; i < NS; i++)
    begin : g_rot
        logic signed [TRIG_WIDTH-1:0] dx;
        logic signed [TRIG_WIDTH-1:0] dy;
        logic signed [ZW-1:0]         at;

        assign dx = y_reg[i] >>> i;
        assign dy = x_reg[i] >>> i;
        assign at = $signed(ZW'(atan_turn(i)));

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                if (!z_reg[i][ZW-1])
                begin
                    x_reg[i+1] <= x_reg[i] - dx;
                    y_reg[i+1] <= y_reg[i] + dy;
                    z_reg[i+1] <= z_reg[i] - at;
                end
                else
                begin
                    x_reg[i+1] <= x_reg[i] + dx;
                    y_reg[i+1] <= y_reg[i] - dy;
                    z_reg[i+1] <= z_reg[i] + at;
                end
                q_reg[i+1] <= q_reg[i];
            end
        end
    end

    // put the quadrant back
    always_comb
    begin
        case (q_reg[NS])
            2'd0:
            begin
                cos_out = x_reg[NS];
                sin_out = y_reg[NS];
            end
            2'd1:
            begin
                cos_out = -y_reg[NS];
                sin_out = x_reg[NS];
            end
            2'd2:
            begin
                cos_out = -x_reg[NS];
                sin_out = -y_reg[NS];
            end
            default:
            begin
                cos_out = y_reg[NS];
                sin_out = -x_reg[NS];
            end
        endcase
    end

endmodule

FILE: rtl/core/shdd_radius.sv
`timescale 1ns / 1ps
// radius, inverse radius and inverse cube pipeline with singularity flag
module shdd_radius
    import shdd_pkg::*;
#(
    parameter int DATA_WIDTH = 32
)
(
    input  logic                         clk,
    input  logic                         en,
    input  logic signed [DATA_WIDTH-1:0] pos_x,
    input  logic signed [DATA_WIDTH-1:0] pos_y,
    input  logic signed [DATA_WIDTH-1:0] pos_z,
    output logic [DATA_WIDTH-1:0]        inv3,
    output logic                         singular
);

    localparam int W  = DATA_WIDTH;
    localparam int F  = DATA_WIDTH - 8;
    localparam int SW = 2 * DATA_WIDTH;
    localparam int PW = 2 * DATA_WIDTH - 2;

    localparam logic [W-1:0] SING_LIMIT = W'(1) << (W - 15);
    localparam logic [W-1:0] REM_INIT   = W'(1) << (W - 15);

    logic [W-1:0]    mag_x;
    logic [W-1:0]    mag_y;
    logic [W-1:0]    mag_z;
    logic [SW-1:0]   sq_reg [0:2];

    logic [SW-1:0]   rem_reg  [0:W];
    logic [W-1:0]    root_reg [0:W];

    logic [W-1:0]    drem_reg [0:W-1];
    logic [W-1:0]    dv_reg   [0:W-1];
    logic [W-2:0]    quo_reg  [0:W-1];
    logic            dsat_reg [0:W-1];

    logic [W-2:0]    inv1;
    logic [W-2:0]    inv1_d_reg;
    logic [PW-1:0]   p2;
    logic [PW:0]     rnd2;
    logic [PW:0]     v2;
    logic            o2;
    logic [W-2:0]    inv2_reg;
    logic            flag2_reg;
    logic [PW-1:0]   p3;
    logic [PW:0]     rnd3;
    logic [PW:0]     v3;
    logic            o3;
    logic [W-2:0]    inv3_reg;
    logic            flag3_reg;

    assign mag_x = pos_x[W-1] ? W'(-pos_x) : W'(pos_x);
    assign mag_y = pos_y[W-1] ? W'(-pos_y) : W'(pos_y);
    assign mag_z = pos_z[W-1] ? W'(-pos_z) : W'(pos_z);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sq_reg[0]   <= SW'(mag_x) * SW'(mag_x);
            sq_reg[1]   <= SW'(mag_y) * SW'(mag_y);
            sq_reg[2]   <= SW'(mag_z) * SW'(mag_z);
            rem_reg[0]  <= sq_reg[0] + sq_reg[1] + sq_reg[2];
            root_reg[0] <= '0;
        end
    end

    // square root, one result bit a stage
    for (genvar i = 0; i < W; i++)
    begin : g_sqrt
        localparam int B = W - 1 - i;
        logic [SW:0] trial;
        logic        fits;

        assign trial = ((SW + 1)'(root_reg[i]) << (B + 1)) + ((SW + 1)'(1) << (2 * B));
        assign fits  = trial <= (SW + 1)'(rem_reg[i]);

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[i+1]  <= fits ? rem_reg[i] - SW'(trial) : rem_reg[i];
                root_reg[i+1] <= fits ? (root_reg[i] | (W'(1) << B)) : root_reg[i];
            end
        end
    end

    // quotient bits above the data range are all zero unless the radius is tiny
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            drem_reg[0] <= REM_INIT;
            dv_reg[0]   <= root_reg[W];
            quo_reg[0]  <= '0;
            dsat_reg[0] <= root_reg[W] <= SING_LIMIT;
        end
    end

    // restoring division of the unit square by the radius
    for (genvar j = 0; j < W - 1; j++)
    begin : g_div
        localparam int B = W - 2 - j;
        logic [W:0] shifted;
        logic       take;

        assign shifted = {drem_reg[j], 1'b0};
        assign take    = shifted >= {1'b0, dv_reg[j]};

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                drem_reg[j+1] <= take ? W'(shifted - {1'b0, dv_reg[j]}) : W'(shifted);
                quo_reg[j+1]  <= take ? (quo_reg[j] | ((W - 1)'(1) << B)) : quo_reg[j];
                dv_reg[j+1]   <= dv_reg[j];
                dsat_reg[j+1] <= dsat_reg[j];
            end
        end
    end

    assign inv1 = quo_reg[W-1];

    always_comb
    begin
        p2   = PW'(inv1) * PW'(inv1);
        rnd2 = {1'b0, p2} + ((PW + 1)'(1) << (F - 1));
        v2   = rnd2 >> F;
        o2   = |v2[PW:W-1];
        p3   = PW'(inv2_reg) * PW'(inv1_d_reg);
        rnd3 = {1'b0, p3} + ((PW + 1)'(1) << (F - 1));
        v3   = rnd3 >> F;
        o3   = |v3[PW:W-1];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            inv1_d_reg <= inv1;
            inv2_reg   <= o2 ? {(W - 1){1'b1}} : v2[W-2:0];
            flag2_reg  <= dsat_reg[W-1] | o2;
            inv3_reg   <= (flag2_reg | o3) ? {(W - 1){1'b1}} : v3[W-2:0];
            flag3_reg  <= flag2_reg | o3;
        end
    end

    assign inv3     = {1'b0, inv3_reg};
    assign singular = flag3_reg;

endmodule

FILE: rtl/core/sail_hill_dynamics_derivative.sv
`timescale 1ns / 1ps
// top level: hill equation derivatives with solar sail acceleration
//
// One item is taken every clock while the pipe is not held, and its result leaves
// through the output register. The pipeline depth is set by the square root and the
// inverse-radius divider, each of which resolves one bit per pipeline stage;
// the cordic angle units and the sail multiplier chain run alongside and are
// delayed to meet them. A stall on the result side holds every stage in place,
// so item_stall follows result_stall while a result is waiting. Configuration
// writes are always ready and should be made only while no item is in flight.
module sail_hill_dynamics_derivative
    import shdd_pkg::*;
#(
    parameter int DATA_WIDTH    = 32,
    parameter int ANGLE_WIDTH   = 16,
    parameter int CORDIC_STAGES = 16
)
(
    input  logic                                                   clk,
    input  logic                                                   rst_n,
    input  logic                                                   item_valid,
    output logic                                                   item_stall,
    input  logic signed [DATA_WIDTH-1:0]                           pos_x,
    input  logic signed [DATA_WIDTH-1:0]                           pos_y,
    input  logic signed [DATA_WIDTH-1:0]                           pos_z,
    input  logic signed [DATA_WIDTH-1:0]                           vel_x,
    input  logic signed [DATA_WIDTH-1:0]                           vel_y,
    input  logic signed [DATA_WIDTH-1:0]                           vel_z,
    input  logic [ANGLE_WIDTH-1:0]                                 cone_angle,
    input  logic [ANGLE_WIDTH-1:0]                                 clock_angle,
    output logic                                                   result_valid,
    input  logic                                                   result_stall,
    output logic signed [DATA_WIDTH-1:0]                           dpos_x,
    output logic signed [DATA_WIDTH-1:0]                           dpos_y,
    output logic signed [DATA_WIDTH-1:0]                           dpos_z,
    output logic signed [DATA_WIDTH-1:0]                           dvel_x,
    output logic signed [DATA_WIDTH-1:0]                           dvel_y,
    output logic signed [DATA_WIDTH-1:0]                           dvel_z,
    output logic                                                   near_singular,
    input  logic                                                   cfg_valid,
    output logic                                                   cfg_ready,
    input  logic [1:0]                                             cfg_index,
    input  logic [((DATA_WIDTH > 32) ? DATA_WIDTH : 32)-1:0]       cfg_data
);

    localparam int W    = DATA_WIDTH;
    localparam int NS   = (CORDIC_STAGES > MAX_STAGES) ? MAX_STAGES : CORDIC_STAGES;
    localparam int LR   = 2 * DATA_WIDTH + 4;
    localparam int LS   = NS + 7;
    localparam int DS   = LR + 1 - LS;
    localparam int OL   = LR + 2;
    localparam int SUMW = DATA_WIDTH + 3;
    localparam int XW   = MID_WIDTH + 1;

    localparam logic signed [SUMW-1:0] SMAX = $signed(SUMW'({1'b0, {(W - 1){1'b1}}}));
    localparam logic signed [SUMW-1:0] SMIN = -SMAX - SUMW'(1);

    typedef struct packed {
        logic signed [W-1:0] px;
        logic signed [W-1:0] py;
        logic signed [W-1:0] pz;
        logic signed [W-1:0] vx;
        logic signed [W-1:0] vy;
        logic signed [W-1:0] vz;
    } kin_t;

    typedef struct packed {
        logic signed [W-1:0] ax;
        logic signed [W-1:0] ay;
        logic signed [W-1:0] az;
    } srp_t;

    logic                           adv;
    logic [OL:1]                    vld_reg;

    logic signed [COEF_WIDTH-1:0]   coef_quad_reg;
    logic signed [COEF_WIDTH-1:0]   coef_lin_reg;
    logic signed [COEF_WIDTH-1:0]   coef_const_reg;
    logic signed [W-1:0]            srp_scale_reg;

    logic signed [TRIG_WIDTH-1:0]   ca_w;
    logic signed [TRIG_WIDTH-1:0]   sa_w;
    logic signed [TRIG_WIDTH-1:0]   cb_w;
    logic signed [TRIG_WIDTH-1:0]   sb_w;

    logic signed [TRIG_WIDTH-1:0]   ca1_reg, sa1_reg, cb1_reg, sb1_reg;
    logic signed [TRIG_WIDTH-1:0]   ca2_reg, sa2_reg, cb2_reg, sb2_reg;
    logic signed [TRIG_WIDTH-1:0]   ca3_reg, sa3_reg, cb3_reg, sb3_reg;
    logic signed [TRIG_WIDTH-1:0]   cb4_reg, sb4_reg;
    logic signed [MID_WIDTH-1:0]    m1_reg;
    logic signed [W-1:0]            gc2_reg, gc3_reg, gc4_reg, gc5_reg;
    logic signed [XW-1:0]           inner_reg;
    logic signed [MID_WIDTH-1:0]    m2_reg;
    logic signed [MID_WIDTH-1:0]    tt_reg;
    logic signed [XW-1:0]           radial_reg;
    logic signed [XW-1:0]           ny_reg;
    logic signed [XW-1:0]           nz_reg;
    srp_t                           srp6_reg;
    srp_t                           sd_reg [1:DS];

    kin_t                           kin_in;
    kin_t                           kin_reg [1:LR+1];

    logic [W-1:0]                   inv3_w;
    logic                           sing_w;
    logic signed [W-1:0]            prx_reg, pry_reg, prz_reg;
    logic                           flag_d_reg;

    logic signed [SUMW-1:0]         sum_x;
    logic signed [SUMW-1:0]         sum_y;
    logic signed [SUMW-1:0]         sum_z;

    logic signed [W-1:0]            dpos_x_reg, dpos_y_reg, dpos_z_reg;
    logic signed [W-1:0]            dvel_x_reg, dvel_y_reg, dvel_z_reg;
    logic                           near_reg;

    function automatic logic signed [W-1:0] clamp(input logic signed [SUMW-1:0] v);
        logic signed [SUMW-1:0] c;
        c = (v > SMAX) ? SMAX : ((v < SMIN) ? SMIN : v);
        return W'(c);
    endfunction

    // whole pipe moves unless a finished result is held back
    assign adv        = !(vld_reg[OL] && result_stall);
    assign item_stall = !adv;
    assign cfg_ready  = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (adv)
        begin
            vld_reg <= {vld_reg[OL-1:1], item_valid};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coef_quad_reg  <= '0;
            coef_lin_reg   <= '0;
            coef_const_reg <= '0;
            srp_scale_reg  <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_COEF_QUAD:  coef_quad_reg  <= cfg_data[COEF_WIDTH-1:0];
                REG_COEF_LIN:   coef_lin_reg   <= cfg_data[COEF_WIDTH-1:0];
                REG_COEF_CONST: coef_const_reg <= cfg_data[COEF_WIDTH-1:0];
                REG_SRP_SCALE:  srp_scale_reg  <= cfg_data[W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    shdd_cordic #(
        .ANGLE_WIDTH (ANGLE_WIDTH),
        .STAGES      (CORDIC_STAGES)
    ) u_cone (
        .clk     (clk),
        .en      (adv),
        .angle   (cone_angle),
        .cos_out (ca_w),
        .sin_out (sa_w)
    );

    shdd_cordic #(
        .ANGLE_WIDTH (ANGLE_WIDTH),
        .STAGES      (CORDIC_STAGES)
    ) u_clock (
        .clk     (clk),
        .en      (adv),
        .angle   (clock_angle),
        .cos_out (cb_w),
        .sin_out (sb_w)
    );

    shdd_radius #(
        .DATA_WIDTH (DATA_WIDTH)
    ) u_radius (
        .clk      (clk),
        .en       (adv),
        .pos_x    (pos_x),
        .pos_y    (pos_y),
        .pos_z    (pos_z),
        .inv3     (inv3_w),
        .singular (sing_w)
    );

    // sail acceleration chain
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            ca1_reg    <= ca_w;
            sa1_reg    <= sa_w;
            cb1_reg    <= cb_w;
            sb1_reg    <= sb_w;

            m1_reg     <= MID_WIDTH'(mul_rnd(64'(coef_quad_reg), 64'(ca1_reg),
                                             TRIG_FRAC, MID_WIDTH));
            gc2_reg    <= W'(mul_rnd(64'(srp_scale_reg), 64'(ca1_reg), TRIG_FRAC, W));
            ca2_reg    <= ca1_reg;
            sa2_reg    <= sa1_reg;
            cb2_reg    <= cb1_reg;
            sb2_reg    <= sb1_reg;

            inner_reg  <= XW'(m1_reg) + XW'(coef_lin_reg);
            gc3_reg    <= gc2_reg;
            ca3_reg    <= ca2_reg;
            sa3_reg    <= sa2_reg;
            cb3_reg    <= cb2_reg;
            sb3_reg    <= sb2_reg;

            m2_reg     <= MID_WIDTH'(mul_rnd(64'(inner_reg), 64'(ca3_reg),
                                             TRIG_FRAC, MID_WIDTH));
            tt_reg     <= MID_WIDTH'(mul_rnd(64'(inner_reg), 64'(sa3_reg),
                                             TRIG_FRAC, MID_WIDTH));
            gc4_reg    <= gc3_reg;
            cb4_reg    <= cb3_reg;
            sb4_reg    <= sb3_reg;

            radial_reg <= XW'(m2_reg) + XW'(coef_const_reg);
            ny_reg     <= -XW'(mul_rnd(64'(tt_reg), 64'(sb4_reg), TRIG_FRAC, MID_WIDTH));
            nz_reg     <= -XW'(mul_rnd(64'(tt_reg), 64'(cb4_reg), TRIG_FRAC, MID_WIDTH));
            gc5_reg    <= gc4_reg;

            srp6_reg.ax <= W'(mul_rnd(64'(gc5_reg), 64'(radial_reg), TRIG_FRAC, W));
            srp6_reg.ay <= W'(mul_rnd(64'(gc5_reg), 64'(ny_reg), TRIG_FRAC, W));
            srp6_reg.az <= W'(mul_rnd(64'(gc5_reg), 64'(nz_reg), TRIG_FRAC, W));
        end
    end

    // delay lines to meet the radius pipeline
    assign kin_in = '{px: pos_x, py: pos_y, pz: pos_z, vx: vel_x, vy: vel_y, vz: vel_z};

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            sd_reg[1] <= srp6_reg;
            for (int i = 2; i <= DS; i++)
            begin
                sd_reg[i] <= sd_reg[i-1];
            end
            kin_reg[1] <= kin_in;
            for (int i = 2; i <= LR + 1; i++)
            begin
                kin_reg[i] <= kin_reg[i-1];
            end
        end
    end

    // gravity terms and final sums
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            prx_reg    <= W'(mul_rnd(64'(kin_reg[LR].px), 64'(inv3_w), W - 8, W));
            pry_reg    <= W'(mul_rnd(64'(kin_reg[LR].py), 64'(inv3_w), W - 8, W));
            prz_reg    <= W'(mul_rnd(64'(kin_reg[LR].pz), 64'(inv3_w), W - 8, W));
            flag_d_reg <= sing_w;
        end
    end

    always_comb
    begin
        sum_x = SUMW'(kin_reg[LR+1].vy) + SUMW'(kin_reg[LR+1].vy)
              + SUMW'(kin_reg[LR+1].px) + SUMW'(kin_reg[LR+1].px)
              + SUMW'(kin_reg[LR+1].px) - SUMW'(prx_reg) + SUMW'(sd_reg[DS].ax);
        sum_y = -SUMW'(kin_reg[LR+1].vx) - SUMW'(kin_reg[LR+1].vx)
              - SUMW'(pry_reg) + SUMW'(sd_reg[DS].ay);
        sum_z = -SUMW'(kin_reg[LR+1].pz) - SUMW'(prz_reg) + SUMW'(sd_reg[DS].az);
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            dpos_x_reg <= kin_reg[LR+1].vx;
            dpos_y_reg <= kin_reg[LR+1].vy;
            dpos_z_reg <= kin_reg[LR+1].vz;
            dvel_x_reg <= clamp(sum_x);
            dvel_y_reg <= clamp(sum_y);
            dvel_z_reg <= clamp(sum_z);
            near_reg   <= flag_d_reg;
        end
    end

    assign result_valid  = vld_reg[OL];
    assign dpos_x        = dpos_x_reg;
    assign dpos_y        = dpos_y_reg;
    assign dpos_z        = dpos_z_reg;
    assign dvel_x        = dvel_x_reg;
    assign dvel_y        = dvel_y_reg;
    assign dvel_z        = dvel_z_reg;
    assign near_singular = near_reg;

`ifndef ASSERT_OFF
    a_freeze: assert property (@(posedge clk) disable iff (!rst_n)
        !adv |=> $stable(vld_reg))
        else $error("valid chain moved while the pipe was held");

    a_enter: assert property (@(posedge clk) disable iff (!rst_n)
        (item_valid && !item_stall) |=> vld_reg[1])
        else $error("accepted transfer missing from first stage");

    a_drain: assert property (@(posedge clk) disable iff (!rst_n)
        (vld_reg[OL-1] && adv) |=> result_valid)
        else $error("item lost before the output register");
`endif

endmodule
